FILE: hw/rtl/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types and constants for the weighted random select block.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int RATE_W = 32;
    localparam int ID_W   = 8;
    localparam int FRAC_W = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int SUM_W  = 38;

    // the total is multiplied in two halves on one narrow multiplier
    localparam int PART_W = SUM_W / 2;
    localparam int PP_W   = FRAC_W + PART_W;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [ID_W-1:0]  id;
    } row_t;

endpackage

FILE: hw/rtl/wrs_mult.sv
// ----------------------------------------------------------------------------
// wrs_mult
// Iterative target multiplier: fraction times total, shifted right by 16,
// built from two partial products on one shared 16x19 multiplier.
// ----------------------------------------------------------------------------
module wrs_mult
    import wrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FRAC_W-1:0] frac,
    input  logic [SUM_W-1:0]  total,
    output logic              done,
    output logic [SUM_W-1:0]  target
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_LO   = 2'd1;
    localparam logic [1:0] M_HI   = 2'd2;
    localparam logic [1:0] M_SUM  = 2'd3;

    localparam int PROD_W = FRAC_W + SUM_W;

    logic [1:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [FRAC_W-1:0] frac_reg;
    logic [SUM_W-1:0]  total_reg;
    logic [PP_W-1:0]   lo_reg;
    logic [PP_W-1:0]   hi_reg;
    logic [SUM_W-1:0]  target_reg;

    logic [PART_W-1:0] part;
    logic [PP_W-1:0]   mul_out;
    logic [PROD_W-1:0] prod;

    // the shared multiplier takes the low half first, then the high half
    assign part    = (state_reg == M_LO) ? total_reg[PART_W-1:0]
                                         : total_reg[SUM_W-1:PART_W];
    assign mul_out = {{PART_W{1'b0}}, frac_reg} * {{FRAC_W{1'b0}}, part};
    assign prod    = {hi_reg, {PART_W{1'b0}}} + {{PART_W{1'b0}}, lo_reg};

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_LO;
                end
            end
            M_LO:
            begin
                state_next = M_HI;
            end
            M_HI:
            begin
                state_next = M_SUM;
            end
            M_SUM:
            begin
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            frac_reg  <= frac;
            total_reg <= total;
        end
        if (state_reg == M_LO)
        begin
            lo_reg <= mul_out;
        end
        if (state_reg == M_HI)
        begin
            hi_reg <= mul_out;
        end
        if (state_reg == M_SUM)
        begin
            target_reg <= prod[PROD_W-1:FRAC_W];
        end
    end

    assign done   = done_reg;
    assign target = target_reg;

endmodule

FILE: hw/rtl/wrs_table.sv
// ----------------------------------------------------------------------------
// wrs_table
// Cumulative sum table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wrs_table
    import wrs_pkg::*;
#(
    parameter int DEPTH = TABLE_ENTRIES_DEF,
    parameter int AW    = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  row_t          wr_row,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output row_t          rd_row
);

    row_t mem [DEPTH];
    row_t rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

FILE: hw/rtl/weighted_random_select_top.sv
// ----------------------------------------------------------------------------
// weighted_random_select_top
// Roulette wheel selection over a table of running rate totals.
// ----------------------------------------------------------------------------
// Takes one command at a time. Clear, add and unused commands go from idle
// straight to the result state. A draw runs the fraction times total product
// on a 16x19 multiplier in two halves, then a binary search of the sum table
// through its single registered read port, each step a read state and a
// compare state, then one more read for the id. The result waits in an output
// register, so a finished result that is not yet taken does not hold up the
// next command until that command is itself done. The table needs no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module weighted_random_select_top
    import wrs_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [RATE_W-1:0] rate,
    input  logic [ID_W-1:0]   entry_id,
    input  logic [FRAC_W-1:0] random_fraction,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [ID_W-1:0]   selected_id,
    output logic [STAT_W-1:0] status,
    output logic [SUM_W-1:0]  total_rate
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_FWAIT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [SUM_W-1:0]  target_reg, target_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [ID_W-1:0]   sel_id_reg, sel_id_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [SUM_W-1:0]  total_out_reg, total_out_next;

    logic              accept;
    logic              full;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sat_sum;
    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid;
    logic [IDX_W-1:0]  new_lo;
    logic [IDX_W-1:0]  new_hi;

    logic              wr_en;
    row_t              wr_row;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    row_t              rd_row;

    logic              mul_start;
    logic              mul_done;
    logic [SUM_W-1:0]  mul_target;

    assign accept  = req_valid && (state_reg == S_IDLE);
    assign full    = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign sum_ext = {1'b0, total_reg} + {{(SUM_W + 1 - RATE_W){1'b0}}, rate};
    assign sat_sum = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    assign cnt_m1  = count_reg - 1'b1;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];

    assign wr_row.sum = sat_sum;
    assign wr_row.id  = entry_id;

    // lower bound search: first stored sum at or above the target
    always_comb
    begin
        if (rd_row.sum >= target_reg)
        begin
            new_lo = lo_reg;
            new_hi = mid;
        end
        else
        begin
            new_lo = mid + 1'b1;
            new_hi = hi_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        target_next     = target_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        sel_id_next     = sel_id_reg;
        status_next     = status_reg;
        total_out_next  = total_out_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = lo_reg;
        mul_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_id_next     = '0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    unique case (command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        CMD_ADD:
                        begin
                            if (rate != '0)
                            begin
                                if (full)
                                begin
                                    res_status_next = ST_FULL;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    total_next = sat_sum;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        CMD_DRAW:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mul_start  = 1'b1;
                                lo_next    = '0;
                                hi_next    = cnt_m1[IDX_W-1:0];
                                state_next = S_MUL;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    target_next = mul_target;
                    state_next  = (lo_reg < hi_reg) ? S_RD : S_FETCH;
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = mid;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                lo_next    = new_lo;
                hi_next    = new_hi;
                state_next = (new_lo < new_hi) ? S_RD : S_FETCH;
            end
            S_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = lo_reg;
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                res_id_next = rd_row.id;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // output slot is free or being emptied this cycle
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    sel_id_next    = res_id_reg;
                    status_next    = res_status_reg;
                    total_out_next = total_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        target_reg     <= target_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        sel_id_reg     <= sel_id_next;
        status_reg     <= status_next;
        total_out_reg  <= total_out_next;
    end

    wrs_mult u_mult (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .frac   (random_fraction),
        .total  (total_reg),
        .done   (mul_done),
        .target (mul_target)
    );

    wrs_table #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_row  (wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign selected_id = sel_id_reg;
    assign status      = status_reg;
    assign total_rate  = total_out_reg;

endmodule

FILE: hw/rtl/wrs_checker.sv
// ----------------------------------------------------------------------------
// wrs_checker
// Port level checks for the weighted random select block.
// ----------------------------------------------------------------------------
module wrs_checker
    import wrs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input logic [ID_W-1:0]   selected_id,
    input logic [STAT_W-1:0] status,
    input logic [SUM_W-1:0]  total_rate
);

    // a stalled result stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(selected_id) && $stable(status)
            && $stable(total_rate))
        else $error("stalled result changed");

    // every taken command makes the block busy in the next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken back to back");

    // an empty table means no entries and a zero total
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> selected_id == '0 && total_rate == '0)
        else $error("empty draw with nonzero id or total");

    // a full table holds nonzero rates
    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> selected_id == '0 && total_rate != '0)
        else $error("full status with zero total or nonzero id");

endmodule

bind weighted_random_select_top wrs_checker u_wrs_checker (.*);

FILE: tb/wrs_selection_checker.sv
// ----------------------------------------------------------------------------
// wrs_selection_checker
// Watches both channels of the weighted random select block, keeps its own
// copy of the running-sum table and compares every response transfer with
// the oldest prediction.
// ----------------------------------------------------------------------------
module wrs_selection_checker
    import wrs_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [RATE_W-1:0] rate,
    input  logic [ID_W-1:0]   entry_id,
    input  logic [FRAC_W-1:0] random_fraction,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  logic [ID_W-1:0]   selected_id,
    input  logic [STAT_W-1:0] status,
    input  logic [SUM_W-1:0]  total_rate,
    output int                mismatch_count,
    output int                picks_pending
);

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [STAT_W-1:0] stat;
        logic [SUM_W-1:0]  total;
    } pick_t;

    logic [SUM_W-1:0] wheel_sums [TABLE_ENTRIES];
    logic [ID_W-1:0]  wheel_ids  [TABLE_ENTRIES];
    int               wheel_count;
    logic [SUM_W-1:0] wheel_total;
    pick_t            expected_picks [$];

    // apply one command to the local table and return the response it should give
    function automatic pick_t spin_wheel(
        input logic [CMD_W-1:0]  cmd,
        input logic [RATE_W-1:0] r,
        input logic [ID_W-1:0]   id,
        input logic [FRAC_W-1:0] f
    );
        logic [SUM_W:0]          grown;
        logic [FRAC_W+SUM_W-1:0] product;
        logic [SUM_W-1:0]        target;
        int                      slot;
        pick_t                   res;
        res = '0;
        res.stat = ST_OK;
        case (cmd)
            CMD_CLEAR:
            begin
                wheel_count = 0;
                wheel_total = '0;
            end
            CMD_ADD:
            begin
                // a zero rate leaves table and total alone
                if (r != '0)
                begin
                    if (wheel_count >= TABLE_ENTRIES)
                    begin
                        res.stat = ST_FULL;
                    end
                    else
                    begin
                        grown = wheel_total + r;
                        if (grown > SUM_MAX)
                        begin
                            wheel_total = SUM_MAX;
                        end
                        else
                        begin
                            wheel_total = grown[SUM_W-1:0];
                        end
                        wheel_sums[wheel_count] = wheel_total;
                        wheel_ids[wheel_count]  = id;
                        wheel_count++;
                    end
                end
            end
            CMD_DRAW:
            begin
                if (wheel_count == 0)
                begin
                    res.stat = ST_EMPTY;
                end
                else
                begin
                    product = f * wheel_total;
                    target  = product[FRAC_W+SUM_W-1:FRAC_W];
                    slot    = wheel_count - 1;
                    // scan downward so the lowest qualifying slot wins
                    for (int i = wheel_count - 1; i >= 0; i--)
                    begin
                        if (wheel_sums[i] >= target)
                        begin
                            slot = i;
                        end
                    end
                    res.id = wheel_ids[slot];
                end
            end
            default:
            begin
            end
        endcase
        res.total = wheel_total;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pick_t want;
        if (!rst_n)
        begin
            expected_picks.delete();
            wheel_count    = 0;
            wheel_total    = '0;
            mismatch_count = 0;
            picks_pending  <= 0;
        end
        else
        begin
            // response first: it can only belong to an earlier request
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_picks.size() == 0)
                begin
                    $error("response transfer with nothing expected: id %0d status %0d total %0h",
                           selected_id, status, total_rate);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_picks.pop_front();
                    if (selected_id !== want.id)
                    begin
                        $error("selected_id mismatch: expected %0d, actual %0d",
                               want.id, selected_id);
                        mismatch_count++;
                    end
                    if (status !== want.stat)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", want.stat, status);
                        mismatch_count++;
                    end
                    if (total_rate !== want.total)
                    begin
                        $error("total_rate mismatch: expected %0h, actual %0h",
                               want.total, total_rate);
                        mismatch_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                expected_picks.push_back(spin_wheel(command, rate, entry_id, random_fraction));
            end
            picks_pending <= expected_picks.size();
        end
    end

endmodule

FILE: tb/tb_weighted_random_select_top.sv
// ----------------------------------------------------------------------------
// tb_weighted_random_select_top
// Drives clear, add, draw and unused commands into the weighted random select
// block with random idle gaps on both channels, a long response hold-off and
// table fills past capacity; the checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb_weighted_random_select_top;
    import wrs_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int ITEM_TARGET = 1350;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 1000000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic [CMD_W-1:0]  command;
    logic [RATE_W-1:0] rate;
    logic [ID_W-1:0]   entry_id;
    logic [FRAC_W-1:0] random_fraction;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [ID_W-1:0]   selected_id;
    logic [STAT_W-1:0] status;
    logic [SUM_W-1:0]  total_rate;

    int mismatch_count;
    int picks_pending;
    int items_sent;
    bit req_quiet;
    bit rsp_quiet;
    bit hold_off_req;

    weighted_random_select_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .command         (command),
        .rate            (rate),
        .entry_id        (entry_id),
        .random_fraction (random_fraction),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .selected_id     (selected_id),
        .status          (status),
        .total_rate      (total_rate)
    );

    wrs_selection_checker selection_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .command         (command),
        .rate            (rate),
        .entry_id        (entry_id),
        .random_fraction (random_fraction),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .selected_id     (selected_id),
        .status          (status),
        .total_rate      (total_rate),
        .mismatch_count  (mismatch_count),
        .picks_pending   (picks_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        else if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [RATE_W-1:0] rand_rate();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return RATE_W'($urandom_range(1, 16));
            3, 4, 5: return $urandom;
            default: return RATE_W'($urandom_range(1, 32'h0003_ffff));
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] rand_frac();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    task automatic issue_command(
        input logic [CMD_W-1:0]  cmd,
        input logic [RATE_W-1:0] r,
        input logic [ID_W-1:0]   id,
        input logic [FRAC_W-1:0] f
    );
        int idle_len;
        idle_len = req_quiet ? 0 : pick_gap();
        if (idle_len > 0)
        begin
            req_valid <= 1'b0;
            repeat (idle_len) @(posedge clk);
        end
        req_valid       <= 1'b1;
        command         <= cmd;
        rate            <= r;
        entry_id        <= id;
        random_fraction <= f;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // response side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_len;
        forever
        begin
            if (hold_off_req)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                stall_len = rsp_quiet ? 0 : pick_gap();
                if (stall_len > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (stall_len) @(posedge clk);
                end
                rsp_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int scenario;
        rst_n           <= 1'b0;
        req_valid       <= 1'b0;
        command         <= CMD_CLEAR;
        rate            <= '0;
        entry_id        <= '0;
        random_fraction <= '0;
        items_sent      = 0;
        req_quiet       = 1'b0;
        rsp_quiet       = 1'b0;
        hold_off_req    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty draws, unused command, zero rate, field extremes
        issue_command(CMD_DRAW, $urandom, ID_W'($urandom), rand_frac());
        issue_command(CMD_UNUSED, '1, '1, '1);
        issue_command(CMD_ADD, '0, 8'h05, '0);
        issue_command(CMD_DRAW, '1, '1, '1);
        issue_command(CMD_ADD, '1, '1, '0);
        issue_command(CMD_ADD, 32'd1, '0, '1);
        issue_command(CMD_ADD, 32'h0001_0000, 8'ha5, '0);
        issue_command(CMD_DRAW, '0, '0, '0);
        issue_command(CMD_DRAW, '0, '0, '1);
        issue_command(CMD_DRAW, '1, '1, 16'h8000);
        issue_command(CMD_ADD, '0, 8'h33, '1);
        issue_command(CMD_UNUSED, '0, '0, '0);
        issue_command(CMD_CLEAR, '1, '1, '1);
        issue_command(CMD_DRAW, '0, '0, 16'h1234);
        issue_command(CMD_ADD, 32'd1, 8'h5a, '0);
        issue_command(CMD_DRAW, '0, '0, '1);
        issue_command(CMD_DRAW, '0, '0, '0);
        issue_command(CMD_CLEAR, '0, '0, '0);

        // back up the response side while requests keep coming
        issue_command(CMD_ADD, 32'h0000_8000, 8'h11, '0);
        hold_off_req = 1'b1;
        repeat (12)
        begin
            issue_command(($urandom_range(0, 1) != 0) ? CMD_ADD : CMD_DRAW,
                          rand_rate(), ID_W'($urandom), rand_frac());
        end

        while (items_sent < ITEM_TARGET)
        begin
            req_quiet = ($urandom_range(0, 4) == 0);
            rsp_quiet = ($urandom_range(0, 4) == 0);
            scenario  = $urandom_range(0, 9);
            if (scenario < 6)
            begin
                // clear, a few adds, then draws over that table
                issue_command(CMD_CLEAR, $urandom, ID_W'($urandom), FRAC_W'($urandom));
                repeat (($urandom_range(0, 5) == 0) ? $urandom_range(9, 24)
                                                     : $urandom_range(1, 8))
                begin
                    issue_command(CMD_ADD, rand_rate(), ID_W'($urandom),
                                  FRAC_W'($urandom));
                end
                repeat ($urandom_range(1, 10))
                begin
                    issue_command(CMD_DRAW, $urandom, ID_W'($urandom), rand_frac());
                end
            end
            else if (scenario < 7)
            begin
                // fill to capacity with large rates, then push past it
                issue_command(CMD_CLEAR, $urandom, ID_W'($urandom), FRAC_W'($urandom));
                repeat (TABLE_ENTRIES_DEF)
                begin
                    issue_command(CMD_ADD,
                                  ($urandom_range(0, 1) != 0) ? '1 : ($urandom | 32'd1),
                                  ID_W'($urandom), FRAC_W'($urandom));
                end
                repeat ($urandom_range(1, 4))
                begin
                    issue_command(CMD_ADD, rand_rate(), ID_W'($urandom),
                                  FRAC_W'($urandom));
                end
                repeat ($urandom_range(4, 12))
                begin
                    issue_command(CMD_DRAW, $urandom, ID_W'($urandom), rand_frac());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    issue_command(CMD_W'($urandom_range(0, 3)), rand_rate(),
                                  ID_W'($urandom), rand_frac());
                end
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (picks_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("FAIL");
        $finish;
    end

endmodule

FILE: weighted_random_select_top.f
hw/rtl/wrs_pkg.sv
hw/rtl/wrs_mult.sv
hw/rtl/wrs_table.sv
hw/rtl/weighted_random_select_top.sv
hw/rtl/wrs_checker.sv
tb/wrs_selection_checker.sv
tb/tb_weighted_random_select_top.sv
